// ----- rtl/mbde_pkg.sv -----
// Shared types, constants and helper functions for the button debounce event unit.
// Used by mbde_sched, mbde_eval, the top level and the testbench.
`default_nettype none

package mbde_pkg;

  localparam int BUTTONS    = 8;
  localparam int BTN_W      = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int RAW_W      = 8;
  localparam int TIME_W     = 32;
  localparam int LIMIT_W    = 4;
  localparam int NUM_W      = 4;
  localparam int DEB_W      = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam int RAW_LSB    = 0;
  localparam int NOW_LSB    = RAW_LSB + RAW_W;
  localparam int LIMIT_LSB  = NOW_LSB + TIME_W;

  localparam logic [LIMIT_W-1:0] EVENT_CAP  = LIMIT_W'(8);
  localparam logic [DEB_W-1:0]   DEB_RESET  = DEB_W'(20);
  localparam logic [BTN_W-1:0]   FIRST_BTN  = '0;
  localparam logic [BTN_W-1:0]   LAST_BTN   = BTN_W'(BUTTONS - 1);

  typedef struct packed {
    logic [RAW_W-1:0]   raw;
    logic [TIME_W-1:0]  now;
    logic [LIMIT_W-1:0] limit;
    logic               seed;
  } snap_t;

  typedef struct packed {
    logic              valid;
    logic [BTN_W-1:0]  btn;
    snap_t             snap;
  } stage_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             pressed;
    logic [RAW_W-1:0] levels;
  } event_t;

  function automatic logic raw_bit(logic [RAW_W-1:0] raw, logic [BTN_W-1:0] b);
    logic [31:0] bi;
    bi = 32'(b);
    return (bi < RAW_W) ? raw[bi[2:0]] : 1'b0;
  endfunction

  function automatic logic [RAW_W-1:0] stable_view(logic [BUTTONS-1:0] s);
    logic [RAW_W-1:0] v;
    v = '0;
    for (int i = 0; i < RAW_W; i++) begin
      if (i < BUTTONS) begin
        v[i] = s[i];
      end
    end
    return v;
  endfunction

  function automatic logic [NUM_W-1:0] button_num(logic [BTN_W-1:0] b);
    logic [31:0] n;
    n = 32'(b) + 32'd1;
    return n[NUM_W-1:0];
  endfunction

  function automatic logic [LIMIT_W-1:0] sat_limit(logic [LIMIT_W-1:0] l);
    return (l > EVENT_CAP) ? EVENT_CAP : l;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mbde_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Has no dependencies.
`default_nettype none

module mbde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/mbde_sched.sv -----
// Input buffer and scan stage: holds one waiting snapshot and steps through the buttons.
// Depends on mbde_pkg.
`default_nettype none

module mbde_sched (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mbde_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             adv,
  output mbde_pkg::stage_t                 a_stage
);
  import mbde_pkg::*;

  logic               buf_valid_r, buf_valid_nxt;
  snap_t              buf_r, buf_nxt;
  logic               seeded_r, seeded_nxt;
  logic               a_valid_r, a_valid_nxt;
  logic [BTN_W-1:0]   a_btn_r, a_btn_nxt;
  snap_t              a_snap_r, a_snap_nxt;
  logic               accept;
  logic               take;
  logic               a_done;

  assign in_tready = !buf_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign a_done    = !a_valid_r || (a_btn_r == LAST_BTN);
  assign take      = adv && a_done && buf_valid_r;

  always_comb begin
    buf_valid_nxt = (buf_valid_r && !take) || accept;
    buf_nxt       = buf_r;
    if (accept) begin
      buf_nxt.raw   = in_tdata[RAW_LSB +: RAW_W];
      buf_nxt.now   = in_tdata[NOW_LSB +: TIME_W];
      buf_nxt.limit = in_tdata[LIMIT_LSB +: LIMIT_W];
      buf_nxt.seed  = 1'b0;
    end

    a_valid_nxt = a_valid_r;
    a_btn_nxt   = a_btn_r;
    a_snap_nxt  = a_snap_r;
    seeded_nxt  = seeded_r || take;
    if (adv) begin
      if (!a_done) begin
        a_btn_nxt = a_btn_r + BTN_W'(1);
      end else begin
        a_valid_nxt     = buf_valid_r;
        a_btn_nxt       = FIRST_BTN;
        a_snap_nxt      = buf_r;
        a_snap_nxt.seed = !seeded_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      seeded_r    <= 1'b0;
      a_valid_r   <= 1'b0;
      a_btn_r     <= FIRST_BTN;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      seeded_r    <= seeded_nxt;
      a_valid_r   <= a_valid_nxt;
      a_btn_r     <= a_btn_nxt;
    end
    buf_r    <= buf_nxt;
    a_snap_r <= a_snap_nxt;
  end

  assign a_stage.valid = a_valid_r;
  assign a_stage.btn   = a_btn_r;
  assign a_stage.snap  = a_snap_r;

endmodule

`default_nettype wire

// ----- rtl/mbde_eval.sv -----
// Evaluate stage: read-modify-write of the change times, level flops and event output.
// Depends on mbde_pkg; drives the change-time RAM instanced at the top level.
`default_nettype none

module mbde_eval (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mbde_pkg::stage_t                 a_stage,
  input  logic [mbde_pkg::DEB_W-1:0]       deb,
  output logic                             adv,
  output logic [mbde_pkg::BTN_W-1:0]       ram_raddr,
  input  logic [mbde_pkg::TIME_W-1:0]      ram_rdata,
  output logic                             ram_we,
  output logic [mbde_pkg::BTN_W-1:0]       ram_waddr,
  output logic [mbde_pkg::TIME_W-1:0]      ram_wdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mbde_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import mbde_pkg::*;

  logic                b_valid_r;
  logic [BTN_W-1:0]    b_btn_r;
  snap_t               b_snap_r;
  logic [BUTTONS-1:0]  stable_r, stable_nxt;
  logic [BUTTONS-1:0]  last_raw_r, last_raw_nxt;
  logic [LIMIT_W-1:0]  cnt_r, cnt_nxt, cnt_base;
  logic                fwd_valid_r;
  logic [TIME_W-1:0]   fwd_data_r;
  logic                hold_valid_r, hold_valid_nxt;
  logic                hold_ready_r, hold_ready_nxt;
  event_t              hold_r, hold_nxt;
  logic                out_valid_r, out_valid_nxt;
  event_t              out_r, out_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_free;
  logic                active;
  logic                r;
  logic                changed;
  logic [TIME_W-1:0]   time_rd;
  logic [TIME_W-1:0]   t_new;
  logic [TIME_W-1:0]   elapsed;
  logic                qual;
  logic                ev;
  logic                final_btn;
  event_t              ev_new;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = out_free && !hold_ready_r;
  assign active    = adv && b_valid_r;
  assign ram_raddr = adv ? a_stage.btn : b_btn_r;

  assign r         = raw_bit(b_snap_r.raw, b_btn_r);
  assign time_rd   = fwd_valid_r ? fwd_data_r : ram_rdata;
  assign changed   = (r != last_raw_r[b_btn_r]);
  assign t_new     = (changed || b_snap_r.seed) ? b_snap_r.now : time_rd;
  assign elapsed   = b_snap_r.now - t_new;
  assign cnt_base  = (b_btn_r == FIRST_BTN) ? '0 : cnt_r;
  assign qual      = !b_snap_r.seed && (r != stable_r[b_btn_r]) &&
                     (elapsed >= TIME_W'(deb)) && (cnt_base < sat_limit(b_snap_r.limit));
  assign ev        = active && qual;
  assign final_btn = (b_btn_r == LAST_BTN);

  assign ram_we    = active;
  assign ram_waddr = b_btn_r;
  assign ram_wdata = t_new;

  always_comb begin
    stable_nxt   = stable_r;
    last_raw_nxt = last_raw_r;
    cnt_nxt      = cnt_r;
    if (active) begin
      last_raw_nxt[b_btn_r] = r;
      cnt_nxt = cnt_base + LIMIT_W'(ev);
      if (ev || b_snap_r.seed) begin
        stable_nxt[b_btn_r] = r;
      end
    end
    ev_new.num     = button_num(b_btn_r);
    ev_new.pressed = r;
    ev_new.levels  = stable_view(stable_nxt);
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_ready_nxt = hold_ready_r;
    hold_nxt       = hold_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    priority if (hold_ready_r) begin
      if (out_free) begin
        out_nxt        = hold_r;
        out_last_nxt   = 1'b1;
        out_valid_nxt  = 1'b1;
        hold_valid_nxt = 1'b0;
        hold_ready_nxt = 1'b0;
      end
    end else if (active) begin
      priority if (ev && hold_valid_r) begin
        out_nxt        = hold_r;
        out_last_nxt   = 1'b0;
        out_valid_nxt  = 1'b1;
        hold_nxt       = ev_new;
        hold_ready_nxt = final_btn;
      end else if (ev) begin
        if (final_btn) begin
          out_nxt       = ev_new;
          out_last_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
        end else begin
          hold_nxt       = ev_new;
          hold_valid_nxt = 1'b1;
        end
      end else if (hold_valid_r && final_btn) begin
        out_nxt        = hold_r;
        out_last_nxt   = 1'b1;
        out_valid_nxt  = 1'b1;
        hold_valid_nxt = 1'b0;
      end else begin
        hold_valid_nxt = hold_valid_r;
      end
    end else begin
      hold_valid_nxt = hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r    <= 1'b0;
      stable_r     <= '0;
      last_raw_r   <= '0;
      cnt_r        <= '0;
      fwd_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
      hold_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (adv) begin
        b_valid_r <= a_stage.valid;
      end
      stable_r     <= stable_nxt;
      last_raw_r   <= last_raw_nxt;
      cnt_r        <= cnt_nxt;
      fwd_valid_r  <= ram_we && (ram_raddr == ram_waddr);
      hold_valid_r <= hold_valid_nxt;
      hold_ready_r <= hold_ready_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    if (adv) begin
      b_btn_r  <= a_stage.btn;
      b_snap_r <= a_stage.snap;
    end
    fwd_data_r <= t_new;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_DATA_W - NUM_W - 1 - RAW_W)'(0), out_r.levels, out_r.pressed,
                       out_r.num};

endmodule

`default_nettype wire

// ----- rtl/multi_button_debounce_events_unit.sv -----
// Top level of the snapshot-driven button debounce event unit.
// Depends on mbde_pkg, mbde_ram, mbde_sched and mbde_eval.
//
// Usage:
// The in_ channel carries one snapshot per transaction: raw button levels,
// a millisecond timestamp and an event limit. The out_ channel carries one
// edge event per transaction; out_tlast marks the final event of a snapshot.
// A snapshot that flips no button produces no transaction at all.
// cfg_wr_en writes the debounce time; it may only change while the unit is idle.
// Each snapshot is scanned one button per cycle while the output does not stall,
// through a read-modify-write of the change-time RAM; the scan also pauses when
// the final button and the previous event both end up waiting for the output
// register. A new snapshot is accepted while the previous one is still scanning.
// With an idle pipeline an event is held until the next flipping button of its
// snapshot is evaluated, and the last event of a snapshot until its final button
// is evaluated. After reset the debounce time is 20 ms and the first snapshot
// only seeds the state. When the receiver stalls, the scan and the RAM accesses
// freeze and the input side fills its one-entry buffer, then drops in_tready.
`default_nettype none

module multi_button_debounce_events_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // raw_levels [7:0], now_ms [39:8], event_limit [43:40], zero fill above
  input  logic [mbde_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // button_number [3:0], now_pressed [4], stable_levels [12:5], zero fill above
  output logic [mbde_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [mbde_pkg::DEB_W-1:0]       cfg_wr_data
);
  import mbde_pkg::*;

  logic [DEB_W-1:0]   deb_r;
  stage_t             a_stage;
  logic               adv;
  logic [BTN_W-1:0]   ram_raddr;
  logic [TIME_W-1:0]  ram_rdata;
  logic               ram_we;
  logic [BTN_W-1:0]   ram_waddr;
  logic [TIME_W-1:0]  ram_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= DEB_RESET;
    end else if (cfg_wr_en) begin
      deb_r <= cfg_wr_data;
    end
  end

  mbde_sched u_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .a_stage   (a_stage)
  );

  mbde_ram #(
    .WIDTH (TIME_W),
    .DEPTH (BUTTONS)
  ) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mbde_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .a_stage    (a_stage),
    .deb        (deb_r),
    .adv        (adv),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_stall_freezes_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !adv)
    else $error("Scan advanced while the output transaction was stalled.");

  a_scan_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && a_stage.valid && (a_stage.btn != LAST_BTN)) |=>
    (a_stage.valid && (a_stage.btn == $past(a_stage.btn) + BTN_W'(1))))
    else $error("Button scan skipped or lost its snapshot.");

  a_stalled_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && a_stage.valid) |=> (a_stage.valid && $stable(a_stage.btn)))
    else $error("Button scan moved while the pipeline was frozen.");

endmodule

`default_nettype wire

// ----- sim/tb_multi_button_debounce_events_unit.sv -----
// Self-checking testbench for the snapshot-driven button debounce event unit.
// It predicts every edge event from the snapshots it sends and checks them in order.
// Depends on mbde_pkg and multi_button_debounce_events_unit.
`default_nettype none

module tb_multi_button_debounce_events_unit;
  import mbde_pkg::*;

  typedef struct packed {
    logic [7:0]  raw;
    logic [31:0] now_ms;
    logic [3:0]  limit;
  } snapshot_t;

  typedef struct packed {
    logic [3:0] num;
    logic       pressed;
    logic [7:0] levels;
    logic       last;
  } edge_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [DEB_W-1:0] cfg_wr_data = '0;

  multi_button_debounce_events_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  snapshot_t   pending_snaps[$];
  edge_event_t expected_events[$];
  snapshot_t   drv_snap;
  bit          in_taken = 1'b0;
  bit          idle_en = 1'b1;
  int          in_gap = 0;
  int          out_gap = 0;
  int          errors = 0;
  logic [31:0] clock_ms = '0;

  // Debouncer state mirrored by the testbench.
  logic [15:0] deb_time_ms = 16'd20;
  bit          seeded = 1'b0;
  logic [7:0]  stable_lvl = '0;
  logic [7:0]  last_raw = '0;
  logic [31:0] change_ms[8];

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic predict_edges(input logic [7:0] raw, input logic [31:0] now_ms,
                               input logic [3:0] limit);
    edge_event_t ev[8];
    int n;
    logic [3:0] cap;
    logic [31:0] held;
    n = 0;
    cap = (limit > 4'd8) ? 4'd8 : limit;
    if (!seeded) begin
      stable_lvl = raw;
      last_raw = raw;
      for (int i = 0; i < 8; i++) change_ms[i] = now_ms;
      seeded = 1'b1;
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (raw[i] != last_raw[i]) begin
          last_raw[i] = raw[i];
          change_ms[i] = now_ms;
        end
        held = now_ms - change_ms[i];
        if (raw[i] != stable_lvl[i] && held >= {16'd0, deb_time_ms} && n < int'(cap)) begin
          stable_lvl[i] = raw[i];
          ev[n].num = 4'(i + 1);
          ev[n].pressed = raw[i];
          ev[n].levels = stable_lvl;
          ev[n].last = 1'b0;
          n++;
        end
      end
      if (n > 0) ev[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) expected_events.push_back(ev[k]);
    end
  endtask

  // Sender: one snapshot per transaction, with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_snaps.size() > 0 && idle_en && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_tvalid <= 1'b0;
      end else if (pending_snaps.size() > 0) begin
        drv_snap = pending_snaps.pop_front();
        in_tdata <= {4'd0, drv_snap.limit, drv_snap.now_ms, drv_snap.raw};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready with random stall bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predicts on each accepted snapshot and checks each event transaction.
  always @(posedge clk) begin
    edge_event_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_edges(in_tdata[7:0], in_tdata[39:8], in_tdata[43:40]);
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (expected_events.size() == 0) begin
          note_error($sformatf("unexpected event transaction: tdata=%h tlast=%b",
                               out_tdata, out_tlast));
        end else begin
          want = expected_events.pop_front();
          if (out_tdata[3:0] != want.num || out_tdata[4] != want.pressed ||
              out_tdata[12:5] != want.levels || out_tlast != want.last) begin
            note_error({
              $sformatf("event mismatch: expected button %0d pressed %b levels %h last %b",
                        want.num, want.pressed, want.levels, want.last),
              $sformatf(", got button %0d pressed %b levels %h last %b",
                        out_tdata[3:0], out_tdata[4], out_tdata[12:5], out_tlast)});
          end
        end
      end
    end
  end

  task automatic add_snap(input logic [7:0] raw, input logic [31:0] now_ms,
                          input logic [3:0] limit);
    snapshot_t s;
    s.raw = raw;
    s.now_ms = now_ms;
    s.limit = limit;
    pending_snaps.push_back(s);
  endtask

  task automatic wait_drained();
    while (pending_snaps.size() > 0 || in_tvalid || expected_events.size() > 0) begin
      @(posedge clk);
    end
    repeat (32) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    deb_time_ms = value;
  endtask

  // Mostly press and release sequences with bounce, plus time jumps and held levels.
  task automatic random_snaps(input int count);
    logic [7:0] raw;
    logic [3:0] limit;
    int kind;
    raw = last_raw;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      limit = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      if (kind < 6) begin
        clock_ms += $urandom_range(0, int'(deb_time_ms) + int'(deb_time_ms) / 2 + 3);
        if ($urandom_range(0, 2) == 0) raw ^= 8'($urandom & $urandom);
      end else if (kind < 8) begin
        clock_ms += $urandom_range(0, 3);
        raw ^= 8'($urandom);
      end else if (kind == 8) begin
        clock_ms = $urandom;
        raw = 8'($urandom);
      end else begin
        clock_ms += int'(deb_time_ms) + $urandom_range(0, 5);
      end
      add_snap(raw, clock_ms, limit);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) change_ms[i] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset debounce time: seeding, wrap of the time difference, limits.
    add_snap(8'hA5, 32'hFFFF_FFF0, 4'd15);
    add_snap(8'h5A, 32'hFFFF_FFF5, 4'd8);
    add_snap(8'h5A, 32'h0000_0009, 4'd15);
    add_snap(8'hFF, 32'h0000_000A, 4'd8);
    add_snap(8'hFF, 32'h0000_0030, 4'd2);
    add_snap(8'hFF, 32'h0000_0031, 4'd0);
    add_snap(8'hFF, 32'h0000_0032, 4'd8);
    add_snap(8'h00, 32'h0000_0040, 4'd8);
    add_snap(8'h00, 32'h0000_0054, 4'd8);
    add_snap(8'h01, 32'h0000_0060, 4'd8);
    add_snap(8'h00, 32'h0000_0061, 4'd8);
    add_snap(8'h01, 32'h0000_0062, 4'd8);
    add_snap(8'h01, 32'h0000_0075, 4'd8);
    add_snap(8'h01, 32'h0000_0076, 4'd8);
    add_snap(8'h80, 32'hFFFF_FFFF, 4'd1);
    add_snap(8'h80, 32'h0000_0013, 4'd1);
    add_snap(8'h80, 32'h0000_0014, 4'd1);
    wait_drained();

    write_debounce(16'd0);
    add_snap(8'h00, 32'h0000_0000, 4'd8);
    add_snap(8'hFF, 32'h0000_0000, 4'd8);
    add_snap(8'h00, 32'h0000_0000, 4'd3);
    wait_drained();

    write_debounce(16'hFFFF);
    add_snap(8'h00, 32'd100, 4'd8);
    add_snap(8'h00, 32'd65635, 4'd8);
    clock_ms = 32'd65635;
    wait_drained();

    write_debounce(16'd0);
    random_snaps(40);
    wait_drained();

    write_debounce(16'hFFFF);
    random_snaps(30);
    wait_drained();

    write_debounce(16'($urandom_range(1, 50)));
    random_snaps(28);
    wait_drained();

    write_debounce(16'd20);
    idle_en = 1'b0;
    random_snaps(40);
    wait_drained();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
